// File: src/trsm_pkg.sv
// Package for the TCP receive state machine: state and verdict codes, flag and wake
// constants, serial sequence compares, the classified segment and the result records.
// Used by every module of the block; depends on nothing.
package trsm_pkg;

  localparam int TRSM_QUEUE_DEPTH = 2;
  localparam int TRSM_IN_W        = 224;
  localparam int TRSM_OUT_W       = 88;

  typedef enum logic [3:0] {
    ST_CLOSED      = 4'd0,
    ST_LISTEN      = 4'd1,
    ST_SYN_RECV    = 4'd2,
    ST_SYN_SENT    = 4'd3,
    ST_ESTABLISHED = 4'd4,
    ST_CLOSE_WAIT  = 4'd5,
    ST_LAST_ACK    = 4'd6,
    ST_FIN_WAIT_1  = 4'd7,
    ST_FIN_WAIT_2  = 4'd8,
    ST_CLOSING     = 4'd9,
    ST_TIME_WAIT   = 4'd10
  } state_t;

  localparam logic [3:0] ST_LAST_CODE = 4'd10;

  typedef enum logic [1:0] {
    V_DONE  = 2'd0,
    V_DROP  = 2'd1,
    V_STALL = 2'd2
  } verdict_t;

  localparam logic [0:0] CMD_SEGMENT = 1'b0;

  localparam logic [5:0] TCP_FIN = 6'd1;
  localparam logic [5:0] TCP_SYN = 6'd2;
  localparam logic [5:0] TCP_RST = 6'd4;
  localparam logic [5:0] TCP_ACK = 6'd16;
  localparam logic [5:0] TCP_RST_ACK = TCP_RST | TCP_ACK;
  localparam logic [5:0] TCP_SYN_ACK = TCP_SYN | TCP_ACK;

  localparam logic [3:0] W_SEND    = 4'd1;
  localparam logic [3:0] W_RECV    = 4'd2;
  localparam logic [3:0] W_CONNECT = 4'd4;
  localparam logic [3:0] W_ACCEPT  = 4'd8;

  // Segment after decode: flag classes and the compares that need no connection state.
  typedef struct packed {
    logic        cmd;
    logic        force_ok;
    logic [3:0]  forced_state;
    logic        is_rst_ack;
    logic        is_syn;
    logic        is_syn_ack;
    logic        is_ack;
    logic        ackf;
    logic        finf;
    logic        plen_nz;
    logic        stall;
    logic        ack_le_snd;
    logic        accept_full;
    logic [31:0] seq;
    logic [31:0] seq_end;
    logic [31:0] ack;
    logic [15:0] wnd;
    logic [15:0] plen;
    logic [15:0] bfree;
    logic [15:0] buf_left;
    logic [31:0] iss;
  } item_t;

  typedef struct packed {
    state_t      conn_state;
    logic [5:0]  send_ctrl_flags;
    logic        send_reset;
    logic [15:0] store_len;
    logic [3:0]  wake_mask;
    logic        start_timewait;
    logic        release_conn;
    verdict_t    verdict;
    logic [15:0] send_window;
    logic [31:0] recv_next;
  } result_t;

  // a <= b modulo 2^32
  function automatic logic seq_le(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return !d[31];
  endfunction

  // a < b modulo 2^32
  function automatic logic seq_lt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

// File: src/tcp_receive_state_machine.sv
// Top level of the TCP receive state machine: front end, queue and back end joined to
// the stream ports. Depends on trsm_pkg, trsm_front and trsm_back.
//
// Usage: each transfer on the s_ channel is one step for a single connection: a
// received segment header (s_tuser low) or an application command that forces the
// connection state (s_tuser high). Every step yields exactly one transfer on the m_
// channel carrying the state after the step, the control flags and reset to send, the
// bytes to store, waiter wake-ups, time-wait start, release and the verdict.
// Path: each step is written into the front queue, then the back end loads its result
// register from the queue head, and the result is offered on the m_ channel from that
// register.
// Throughput: one step per cycle while results are taken; the back end reads the connection
// registers, evaluates the step and writes them back in the same cycle, so steps can follow
// each other without gaps.
// Stalls: when a result is offered and m_tready is low the result register holds; the
// front queue keeps taking transfers until its QUEUE_DEPTH entries are full, then s_tready drops.
// Reset: rst empties the queue and the result register, puts the connection in
// CLOSED and clears the sequence and window registers.
module tcp_receive_state_machine
  import trsm_pkg::*;
#(
  parameter int QUEUE_DEPTH = TRSM_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // forced_state[3:0] seg_flags[9:4] seg_seq[41:10] seg_seq_end[73:42]
  // seg_ack[105:74] seg_window[121:106] payload_len[137:122] rx_buf_free[153:138]
  // send_next[185:154] new_iss[217:186] accept_full[218], zeros above
  input  logic [TRSM_IN_W-1:0]  s_tdata,
  // cmd
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // conn_state[3:0] send_ctrl_flags[9:4] send_reset[10] store_len[26:11]
  // wake_mask[30:27] start_timewait[31] release_conn[32] send_window[48:33]
  // recv_next[80:49], zeros above
  output logic [TRSM_OUT_W-1:0] m_tdata,
  // verdict
  output logic [1:0]            m_tuser
);

  item_t   q_item;
  logic    q_valid;
  logic    q_ready;
  result_t out_res;

  trsm_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  trsm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res  (out_res)
  );

  // pack the result, conn_state in the lowest bits
  assign m_tdata = {7'd0,
                    out_res.recv_next,
                    out_res.send_window,
                    out_res.release_conn,
                    out_res.start_timewait,
                    out_res.wake_mask,
                    out_res.store_len,
                    out_res.send_reset,
                    out_res.send_ctrl_flags,
                    out_res.conn_state};
  assign m_tuser = out_res.verdict;

`ifndef SYNTHESIS
  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // a reset to the peer only leaves the connection closed
  a_reset_closed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.send_reset |-> out_res.conn_state == ST_CLOSED)
    else $error("reset sent while connection stays open");

  // time-wait start always comes with an ACK and the TIME_WAIT state
  a_timewait: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.start_timewait |->
      out_res.conn_state == ST_TIME_WAIT && out_res.send_ctrl_flags == TCP_ACK)
    else $error("time-wait start without TIME_WAIT and ACK");

  // a stalled segment stores nothing and wakes only the reader
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.verdict == V_STALL |->
      out_res.store_len == 16'd0 && out_res.wake_mask == W_RECV)
    else $error("buffer stall with side effects");
`endif

endmodule

// File: src/trsm_front.sv
// Front end of the TCP receive state machine: takes segment transfers, classifies the
// flags, does the stateless compares and parks the result in a short queue.
// Depends on trsm_pkg.
module trsm_front
  import trsm_pkg::*;
#(
  parameter int QUEUE_DEPTH = TRSM_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [TRSM_IN_W-1:0] s_tdata,
  input  logic                 s_tuser,
  output logic                 q_valid,
  input  logic                 q_ready,
  output item_t                q_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  item_t            queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  item_t            cls;
  logic             push, pop;
  logic [5:0]       flags;
  logic [31:0]      send_next;

  // classify the incoming transfer
  always_comb begin
    flags            = s_tdata[9:4];
    send_next        = s_tdata[185:154];
    cls.cmd          = s_tuser;
    cls.forced_state = s_tdata[3:0];
    cls.force_ok     = s_tdata[3:0] <= ST_LAST_CODE;
    cls.is_rst_ack   = flags == TCP_RST_ACK;
    cls.is_syn       = flags == TCP_SYN;
    cls.is_syn_ack   = flags == TCP_SYN_ACK;
    cls.is_ack       = flags == TCP_ACK;
    cls.ackf         = (flags & TCP_ACK) != 6'd0;
    cls.finf         = (flags & TCP_FIN) != 6'd0;
    cls.seq          = s_tdata[41:10];
    cls.seq_end      = s_tdata[73:42];
    cls.ack          = s_tdata[105:74];
    cls.wnd          = s_tdata[121:106];
    cls.plen         = s_tdata[137:122];
    cls.bfree        = s_tdata[153:138];
    cls.iss          = s_tdata[217:186];
    cls.accept_full  = s_tdata[218];
    cls.plen_nz      = cls.plen != 16'd0;
    cls.stall        = cls.ackf && cls.plen_nz && (cls.bfree < cls.plen);
    cls.buf_left     = cls.bfree - cls.plen;
    cls.ack_le_snd   = seq_le(cls.ack, send_next);
  end

  assign s_tready = count != CNT_FULL;
  assign push     = s_tvalid && s_tready;
  assign q_valid  = count != '0;
  assign pop      = q_valid && q_ready;
  assign q_item   = queue[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls;
    end
  end

endmodule

// File: src/trsm_back.sv
// Back end of the TCP receive state machine: holds the connection state and windows,
// carries out one classified segment or forced state per cycle into a result register
// while that register is empty or being read out. Depends on trsm_pkg.
module trsm_back
  import trsm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  output logic    q_ready,
  input  item_t   q_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  state_t      state, state_next;
  logic [31:0] una, una_next;
  logic [15:0] swnd, swnd_next;
  logic [31:0] rnxt, rnxt_next;
  logic [15:0] rwnd, rwnd_next;
  result_t     res;

  logic        take;
  logic        in_win;
  logic [31:0] win_end;
  logic        wu_ok, wu_early, do_wu;
  logic [31:0] ack_dist;
  logic [32:0] wsum;
  logic [15:0] wsat;
  logic        data_state;

  assign q_ready = !out_valid || out_ready;
  assign take    = q_valid && q_ready;

  always_comb begin
    win_end    = rnxt + ((rwnd != 16'd0) ? {16'd0, rwnd} : 32'd1);
    in_win     = seq_lt(q_item.seq, win_end) && seq_le(rnxt, q_item.seq_end);
    wu_ok      = seq_le(una, q_item.ack) && q_item.ack_le_snd;
    wu_early   = (state == ST_SYN_RECV) || (state == ST_SYN_SENT);
    ack_dist   = q_item.ack - una;
    wsum       = {17'd0, swnd} + {1'b0, ack_dist};
    wsat       = (wsum[32:16] != 17'd0) ? 16'hFFFF : wsum[15:0];
    data_state = (state == ST_ESTABLISHED) || (state == ST_FIN_WAIT_1) ||
                 (state == ST_FIN_WAIT_2);

    state_next = state;
    una_next   = una;
    swnd_next  = swnd;
    rnxt_next  = rnxt;
    rwnd_next  = rwnd;
    do_wu      = 1'b0;

    res.conn_state      = state;
    res.send_ctrl_flags = 6'd0;
    res.send_reset      = 1'b0;
    res.store_len       = 16'd0;
    res.wake_mask       = 4'd0;
    res.start_timewait  = 1'b0;
    res.release_conn    = 1'b0;
    res.verdict         = V_DONE;
    res.send_window     = swnd;
    res.recv_next       = rnxt;

    if (q_item.cmd != CMD_SEGMENT) begin
      if (q_item.force_ok) begin
        state_next = state_t'(q_item.forced_state);
        una_next   = q_item.iss;
        rwnd_next  = q_item.bfree;
      end
    end else if (state == ST_CLOSED) begin
      res.send_reset = 1'b1;
    end else if (q_item.is_rst_ack) begin
      state_next       = ST_CLOSED;
      res.release_conn = 1'b1;
    end else begin
      case (state)
        ST_LISTEN: begin
          if (q_item.is_syn) begin
            state_next          = ST_SYN_RECV;
            una_next            = q_item.iss;
            rnxt_next           = q_item.seq_end;
            rwnd_next           = q_item.bfree;
            res.send_ctrl_flags = TCP_SYN_ACK;
          end
        end
        ST_SYN_SENT: begin
          if (q_item.is_syn_ack) begin
            rnxt_next           = q_item.seq_end;
            do_wu               = 1'b1;
            state_next          = ST_ESTABLISHED;
            res.send_ctrl_flags = TCP_ACK;
            res.wake_mask       = W_CONNECT;
          end
        end
        ST_SYN_RECV: begin
          if (q_item.is_ack) begin
            if (!in_win) begin
              res.verdict = V_DROP;
            end else begin
              do_wu = 1'b1;
              if (q_item.accept_full) begin
                state_next       = ST_CLOSED;
                res.send_reset   = 1'b1;
                res.release_conn = 1'b1;
              end else begin
                state_next    = ST_ESTABLISHED;
                res.wake_mask = W_ACCEPT;
              end
            end
          end
        end
        ST_ESTABLISHED, ST_FIN_WAIT_1, ST_FIN_WAIT_2, ST_LAST_ACK, ST_CLOSE_WAIT: begin
          if (!in_win) begin
            res.verdict = V_DROP;
          end else if (data_state && q_item.stall) begin
            res.verdict   = V_STALL;
            res.wake_mask = W_RECV;
          end else if (!data_state) begin
            if (q_item.ackf) begin
              do_wu = 1'b1;
              if (state == ST_LAST_ACK) begin
                state_next       = ST_CLOSED;
                res.release_conn = 1'b1;
              end
            end
          end else begin
            if (q_item.ackf) begin
              if (q_item.plen_nz) begin
                res.store_len = q_item.plen;
                rwnd_next     = q_item.buf_left;
                res.wake_mask = res.wake_mask | W_RECV;
              end
              if (q_item.plen_nz || (state == ST_ESTABLISHED && q_item.finf)) begin
                rnxt_next           = q_item.seq_end;
                res.send_ctrl_flags = TCP_ACK;
              end
              do_wu = 1'b1;
              if (state == ST_ESTABLISHED && q_item.finf) begin
                state_next    = ST_CLOSE_WAIT;
                res.wake_mask = res.wake_mask | W_RECV;
              end
              if (state == ST_FIN_WAIT_1) begin
                state_next = ST_FIN_WAIT_2;
              end
            end
            if (q_item.finf && ((state == ST_FIN_WAIT_1 && q_item.ackf) ||
                                state == ST_FIN_WAIT_2)) begin
              rnxt_next           = q_item.seq_end;
              state_next          = ST_TIME_WAIT;
              res.send_ctrl_flags = TCP_ACK;
              res.start_timewait  = 1'b1;
            end
          end
        end
        default: begin
          // closing and time wait ignore segments other than RST+ACK
        end
      endcase
    end

    // send window update, only when the acknowledgement lies in [una, snd_nxt]
    if (do_wu && wu_ok) begin
      una_next = q_item.ack;
      if (wu_early) begin
        swnd_next = q_item.wnd;
      end else begin
        swnd_next = wsat;
        if (swnd == 16'd0) begin
          res.wake_mask = res.wake_mask | W_SEND;
        end
      end
    end

    res.conn_state  = state_next;
    res.send_window = swnd_next;
    res.recv_next   = rnxt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLOSED;
      una       <= '0;
      swnd      <= '0;
      rnxt      <= '0;
      rwnd      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        state <= state_next;
        una   <= una_next;
        swnd  <= swnd_next;
        rnxt  <= rnxt_next;
        rwnd  <= rwnd_next;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= res;
    end
  end

endmodule
